@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/fbdc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbdc_pkg
// constants, scale limit table and control types of the baud divisor block
// ----------------------------------------------------------------------------
package fbdc_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CntW      = $clog2(DataW);
  localparam logic [DataW-1:0] ClkHzReset = 32'd32000000;

  // max rate is clk/8, min rate is clk/4194304, halved again in normal mode
  localparam int unsigned MaxRateShift = $clog2(8);
  localparam int unsigned MinRateShift = $clog2(4194304);

  // scale exponent search, exponent = index - ExpBias
  localparam int unsigned NumLimits = 14;
  localparam int unsigned LimitW    = 21;
  localparam logic [3:0]  ExpBias   = 4'd7;
  localparam logic [3:0]  ExpTop    = 4'd14;

  localparam logic [LimitW-1:0] ScaleLimit [NumLimits] = '{
    21'h0000ff, 21'h0001ff, 21'h0003ff, 21'h0007ff, 21'h000fff,
    21'h001ffe, 21'h003ffc, 21'h007ff8, 21'h00fff0, 21'h01ffe0,
    21'h03ffc0, 21'h07ff80, 21'h0fff00, 21'h1ffe00
  };

  typedef struct packed {
    logic load;       // capture the input request
    logic check;      // range check, set up the ratio division
    logic div_start;  // launch the divider on the staged operands
    logic set_scale;  // pick the exponent from the ratio
    logic set_oper;   // stage the divisor division operands
    logic publish;    // write the result register
  } cmd_t;

  typedef struct packed {
    logic reject;     // request outside the supported range
    logic div_done;   // divider finished, quotient valid
  } status_t;

endpackage

@@ hdl/fractional_baud_divisor_calc.sv @@
// ----------------------------------------------------------------------------
// fractional_baud_divisor_calc
// Turns a requested line rate into the two baud register bytes of a
// fractional (divisor plus scale exponent) baud generator. The rate is checked
// against clk/8 and clk/4194304 (both halved in normal mode) and a zero rate
// is rejected; a rejected request skips both divisions and returns zero
// bytes with the accepted flag low. One request is handled at a time: an
// accepted request passes twice through the one-bit-per-cycle divider
// (clock / rate, then the rounded divisor) before its result is written.
// The result sits in an output register, so the next request is taken
// while it waits to be read. The clock register may be written only while
// the block is idle.
// ----------------------------------------------------------------------------
module fractional_baud_divisor_calc
  import fbdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // clock frequency register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,      // system_clock_hz

  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // requested_baud
  input  logic        s_axis_tuser_i,  // double_speed

  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // baud_low_byte [7:0], baud_high_byte [15:8]
  output logic        m_axis_tuser_o   // rate_accepted
);

  cmd_t    cmd;
  status_t status;

  // register writes must land only while idle (the block does not enforce it); the port never stalls
  assign cfg_ready_o = 1'b1;

  // sequencer: owns both handshakes and the step order
  fbdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: clock register, range check, exponent search, shared divider
  fbdc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .baud_i         (s_axis_tdata_i),
    .dbl_i          (s_axis_tuser_i),
    .res_data_o     (m_axis_tdata_o),
    .res_accepted_o (m_axis_tuser_o)
  );

endmodule

@@ hdl/fbdc_div.sv @@
// ----------------------------------------------------------------------------
// fbdc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fbdc_div
  import fbdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o
);

  logic [DataW-1:0] rem_q, quo_q, den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DataW+1:0] trial;
  logic [DataW-1:0] rem_d;
  logic             qbit;

  // zero divisor always subtracts, giving an all-ones quotient
  assign trial = {1'b0, rem_q, quo_q[DataW-1]} - {2'b00, den_q};
  assign qbit  = ~trial[DataW+1];
  assign rem_d = qbit ? trial[DataW-1:0] : {rem_q[DataW-2:0], quo_q[DataW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DataW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DataW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/fbdc_dp.sv @@
// ----------------------------------------------------------------------------
// fbdc_dp
// datapath: clock register, range check, exponent search, operand staging
// ----------------------------------------------------------------------------
module fbdc_dp
  import fbdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_data_i,
  input  logic [DataW-1:0] baud_i,
  input  logic             dbl_i,
  output logic [15:0]      res_data_o,
  output logic             res_accepted_o
);

  logic [DataW-1:0] clk_hz_q;
  logic [DataW-1:0] baud_q, beff_q, num_q, den_q;
  logic             dbl_q, rej_q, minus_one_q;
  logic [3:0]       exp_q;
  logic [15:0]      res_data_q;
  logic             res_acc_q;

  logic [DataW-1:0] rate_hi, rate_lo, beff;
  logic             reject;
  logic [DataW-1:0] quot;
  logic             div_done;
  logic [3:0]       scale_idx;
  logic signed [3:0] exp_s, neg_sh, pos_sh;
  logic [DataW-1:0] c_val, eb, oper_num, oper_den, div_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkHzReset;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_data_i;
    end
  end

  // range limits, halved in normal mode
  always_comb begin
    if (dbl_q) begin
      rate_hi = clk_hz_q >> MaxRateShift;
      rate_lo = clk_hz_q >> MinRateShift;
    end else begin
      rate_hi = clk_hz_q >> (MaxRateShift + 1);
      rate_lo = clk_hz_q >> (MinRateShift + 1);
    end
  end

  assign reject = (baud_q == '0) || (baud_q > rate_hi) || (baud_q < rate_lo);
  assign beff   = dbl_q ? baud_q : {baud_q[DataW-2:0], 1'b0};

  // smallest exponent whose limit the ratio stays under
  always_comb begin
    scale_idx = ExpTop;
    for (int i = NumLimits - 1; i >= 0; i--) begin
      if (quot < DataW'(ScaleLimit[i])) begin
        scale_idx = 4'(i);
      end
    end
  end

  assign exp_s  = $signed(exp_q);
  assign neg_sh = -exp_s - 4'sd3;
  assign pos_sh = exp_s + 4'sd3;
  assign c_val  = clk_hz_q - {beff_q[DataW-4:0], 3'b000};
  assign eb     = beff_q << $unsigned(pos_sh);

  always_comb begin
    if (exp_s <= -4'sd3) begin
      oper_num = (c_val << $unsigned(neg_sh)) + (beff_q >> 1);
      oper_den = beff_q;
    end else if (exp_s < 4'sd0) begin
      oper_num = c_val + (eb >> 1);
      oper_den = eb;
    end else begin
      oper_num = clk_hz_q + (eb >> 1);
      oper_den = eb;
    end
  end

  assign div_res = quot - DataW'(minus_one_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      baud_q <= baud_i;
      dbl_q  <= dbl_i;
    end
    if (cmd_i.check) begin
      rej_q  <= reject;
      beff_q <= beff;
      num_q  <= clk_hz_q;
      den_q  <= beff;
    end
    if (cmd_i.set_scale) begin
      exp_q <= scale_idx - ExpBias;
    end
    if (cmd_i.set_oper) begin
      num_q       <= oper_num;
      den_q       <= oper_den;
      minus_one_q <= ~exp_q[3];
    end
    if (cmd_i.publish) begin
      if (rej_q) begin
        res_data_q <= '0;
        res_acc_q  <= 1'b0;
      end else begin
        res_data_q <= {exp_q, div_res[11:8], div_res[7:0]};
        res_acc_q  <= 1'b1;
      end
    end
  end

  fbdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign status_o.reject   = reject;
  assign status_o.div_done = div_done;
  assign res_data_o        = res_data_q;
  assign res_accepted_o    = res_acc_q;

endmodule

@@ hdl/fbdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbdc_ctrl
// sequencer: steps a request through check, two divisions (skipped on reject) and the result
// ----------------------------------------------------------------------------
module fbdc_ctrl
  import fbdc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RATIO_GO,
    ST_RATIO_WAIT,
    ST_SCALE,
    ST_OPER,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, out_valid_q;
  logic   out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i & ready_q;
        if (in_valid_i && ready_q) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = status_i.reject ? ST_FINISH : ST_RATIO_GO;
      end
      ST_RATIO_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_RATIO_WAIT;
      end
      ST_RATIO_WAIT: begin
        if (status_i.div_done) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.set_scale = 1'b1;
        state_d = ST_OPER;
      end
      ST_OPER: begin
        cmd_o.set_oper = 1'b1;
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.publish = out_free;
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ready_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/fbdc_checker.sv @@
// ----------------------------------------------------------------------------
// fbdc_checker
// port-level checks of the baud divisor block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // rejected requests carry zero bytes
  `ASSERT_IMPLY(a_reject_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o,
                m_axis_tdata_o == 16'h0000)

  // exponent stays within -7..7, never the -8 code
  `ASSERT_IMPLY(a_exp_range, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o,
                m_axis_tdata_o[15:12] != 4'b1000)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
               m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // no request taken in the cycle right after another
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o,
               !s_axis_tready_o)

endmodule

bind fractional_baud_divisor_calc fbdc_checker u_fbdc_checker (.*);
